### hdl/qve_pkg.sv
`timescale 1ns / 1ps

package qve_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_X_SCALE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_X_BIAS    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_Y_SCALE   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_Y_BIAS    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_QUAD_MODE = 3'd4;

  localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
  localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [31:0] z;
    logic        [31:0] colour;
    logic        [31:0] u;
    logic        [31:0] v;
  } vtx_t;

  typedef struct packed {
    logic start;
    vtx_t vtx;
  } item_t;

endpackage

### hdl/qve_axis.sv
`timescale 1ns / 1ps

module qve_axis import qve_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] pos_i,
  input  logic signed [31:0] scale_i,
  input  logic signed [31:0] bias_i,
  output logic signed [31:0] res_o
);

  localparam logic signed [63:0] Round = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0] prod_d;
  logic signed [63:0] prod_q;
  logic signed [63:0] rnd;
  logic signed [63:0] quo;
  logic signed [64:0] sum;

  assign prod_d = pos_i * scale_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // round half up, then floor shift
  assign rnd = prod_q + Round;
  assign quo = rnd >>> FRAC_BITS;
  assign sum = $signed({{33{bias_i[31]}}, bias_i}) + $signed({quo[63], quo});

  always_comb begin
    if (sum > SAT_MAX) begin
      res_o = 32'sh7fffffff;
    end else if (sum < SAT_MIN) begin
      res_o = 32'sh80000000;
    end else begin
      res_o = sum[31:0];
    end
  end

endmodule

### hdl/qve_expand.sv
`timescale 1ns / 1ps

module qve_expand import qve_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        quad_mode_i,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        item_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output vtx_t        out_vtx_o,
  output logic [15:0] out_count_o,
  output logic        out_last_o
);

  localparam logic [2:0] V_A_FIRST = 3'd0;
  localparam logic [2:0] V_MIX_BA  = 3'd1;
  localparam logic [2:0] V_B_FIRST = 3'd2;
  localparam logic [2:0] V_B_AGAIN = 3'd3;
  localparam logic [2:0] V_MIX_AB  = 3'd4;
  localparam logic [2:0] V_A_LAST  = 3'd5;

  vtx_t        a_q, a_d;
  vtx_t        b_q, b_d;
  logic        phase_q, phase_d;
  logic        busy_q, busy_d;
  logic [2:0]  seq_q, seq_d;
  logic [15:0] total_q, total_d;
  logic        out_valid_q, out_valid_d;
  vtx_t        out_vtx_q, out_vtx_d;
  logic [15:0] out_count_q, out_count_d;
  logic        out_last_q, out_last_d;

  logic out_ld;
  logic hold_case;
  logic take;
  logic emit;
  vtx_t seq_vtx;

  assign out_ld    = !out_valid_q || out_ready_i;
  assign hold_case = quad_mode_i && (item_i.start || !phase_q);

  // next pair's first corner may enter while the last vertex goes out
  assign item_ready_o = (!busy_q && (out_ld || hold_case)) ||
                        (busy_q && (seq_q == V_A_LAST) && out_ld && hold_case);
  assign take = item_valid_i && item_ready_o;

  always_comb begin
    case (seq_q) inside
      V_MIX_BA: begin
        seq_vtx        = a_q;
        seq_vtx.x      = b_q.x;
        seq_vtx.u      = b_q.u;
      end
      V_B_FIRST, V_B_AGAIN: begin
        seq_vtx = b_q;
      end
      V_MIX_AB: begin
        seq_vtx        = b_q;
        seq_vtx.x      = a_q.x;
        seq_vtx.u      = a_q.u;
      end
      V_A_FIRST, V_A_LAST: begin
        seq_vtx = a_q;
      end
      default: begin
        seq_vtx = a_q;
      end
    endcase
  end

  always_comb begin
    a_d         = a_q;
    b_d         = b_q;
    phase_d     = phase_q;
    busy_d      = busy_q;
    seq_d       = seq_q;
    total_d     = total_q;
    emit        = 1'b0;
    out_vtx_d   = out_vtx_q;
    out_count_d = out_count_q;
    out_last_d  = out_last_q;

    if (busy_q && out_ld) begin
      emit        = 1'b1;
      total_d     = total_d + 16'd1;
      out_vtx_d   = seq_vtx;
      out_count_d = total_d;
      out_last_d  = (seq_q == V_A_LAST);
      seq_d       = seq_q + 3'd1;
      busy_d      = (seq_q != V_A_LAST);
    end

    if (take) begin
      if (item_i.start) begin
        total_d = 16'd0;
        phase_d = 1'b0;
      end
      if (!quad_mode_i) begin
        emit        = 1'b1;
        total_d     = total_d + 16'd1;
        out_vtx_d   = item_i.vtx;
        out_count_d = total_d;
        out_last_d  = 1'b1;
        phase_d     = 1'b0;
      end else if (!phase_d) begin
        a_d     = item_i.vtx;
        phase_d = 1'b1;
      end else begin
        b_d         = item_i.vtx;
        emit        = 1'b1;
        total_d     = total_d + 16'd1;
        out_vtx_d   = a_q;
        out_count_d = total_d;
        out_last_d  = 1'b0;
        seq_d       = V_MIX_BA;
        busy_d      = 1'b1;
        phase_d     = 1'b0;
      end
    end

    out_valid_d = out_ld ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      busy_q      <= 1'b0;
      seq_q       <= V_A_FIRST;
      total_q     <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      busy_q      <= busy_d;
      seq_q       <= seq_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    b_q         <= b_d;
    out_vtx_q   <= out_vtx_d;
    out_count_q <= out_count_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_vtx_o   = out_vtx_q;
  assign out_count_o = out_count_q;
  assign out_last_o  = out_last_q;

endmodule

### hdl/quad_vertex_expander_unit.sv
`timescale 1ns / 1ps

// channel   handshake                    payload
// cfg       cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
// in        in_valid_i / in_ready_o      start_batch_i, pos_*_i, colour_word_i, tex_*_i
// out       out_valid_o / out_ready_i    out_*_o, batch_count_o, last_o
//
// an input transfer fills the product register; when the expander takes it, the value is
// rounded, biased and saturated and loads the result register, from which the vertex is
// offered; in quad mode a first corner is held instead
// plain mode sustains one vertex per cycle while the output accepts; a quad pair is paced
// by the result register sending one vertex per cycle while the output accepts
// reset clears configuration to identity scale (for FRAC_BITS = 16), pair phase and count;
// no clearing pass; a stalled output holds the result register; the product stage keeps
// accepting while it is empty or draining

module quad_vertex_expander_unit import qve_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               start_batch_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic [31:0]        pos_z_i,
  input  logic [31:0]        colour_word_i,
  input  logic [31:0]        tex_u_i,
  input  logic [31:0]        tex_v_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic [31:0]        out_z_o,
  output logic [31:0]        out_colour_o,
  output logic [31:0]        out_u_o,
  output logic [31:0]        out_v_o,
  output logic [15:0]        batch_count_o,
  output logic               last_o
);

  logic signed [31:0] x_scale_q, x_bias_q, y_scale_q, y_bias_q;
  logic               quad_mode_q;

  logic        s1_valid_q;
  logic        s1_start_q;
  logic [31:0] s1_z_q, s1_colour_q, s1_u_q, s1_v_q;
  logic        in_take;

  item_t item;
  logic  item_ready;
  vtx_t  out_vtx;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_scale_q   <= 32'sd65536;
      x_bias_q    <= 32'sd0;
      y_scale_q   <= 32'sd65536;
      y_bias_q    <= 32'sd0;
      quad_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_X_SCALE:   x_scale_q   <= cfg_data_i;
        REG_X_BIAS:    x_bias_q    <= cfg_data_i;
        REG_Y_SCALE:   y_scale_q   <= cfg_data_i;
        REG_Y_BIAS:    y_bias_q    <= cfg_data_i;
        REG_QUAD_MODE: quad_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !s1_valid_q || item_ready;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_start_q  <= start_batch_i;
      s1_z_q      <= pos_z_i;
      s1_colour_q <= colour_word_i;
      s1_u_q      <= tex_u_i;
      s1_v_q      <= tex_v_i;
    end
  end

  qve_axis #(
    .FRAC_BITS(FRAC_BITS)
  ) u_axis_x (
    .clk_i  (clk_i),
    .en_i   (in_take),
    .pos_i  (pos_x_i),
    .scale_i(x_scale_q),
    .bias_i (x_bias_q),
    .res_o  (item.vtx.x)
  );

  qve_axis #(
    .FRAC_BITS(FRAC_BITS)
  ) u_axis_y (
    .clk_i  (clk_i),
    .en_i   (in_take),
    .pos_i  (pos_y_i),
    .scale_i(y_scale_q),
    .bias_i (y_bias_q),
    .res_o  (item.vtx.y)
  );

  assign item.start      = s1_start_q;
  assign item.vtx.z      = s1_z_q;
  assign item.vtx.colour = s1_colour_q;
  assign item.vtx.u      = s1_u_q;
  assign item.vtx.v      = s1_v_q;

  qve_expand u_expand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .quad_mode_i (quad_mode_q),
    .item_valid_i(s1_valid_q),
    .item_i      (item),
    .item_ready_o(item_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_vtx_o   (out_vtx),
    .out_count_o (batch_count_o),
    .out_last_o  (last_o)
  );

  assign out_x_o      = out_vtx.x;
  assign out_y_o      = out_vtx.y;
  assign out_z_o      = out_vtx.z;
  assign out_colour_o = out_vtx.colour;
  assign out_u_o      = out_vtx.u;
  assign out_v_o      = out_vtx.v;

  // vertices inside one expansion carry consecutive counts
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      !out_valid_o || (batch_count_o == $past(batch_count_o) + 16'd1))
    else $error("batch count skipped inside an expansion");

  // input side only stalls behind a full product stage
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q)
    else $error("input stalled with empty product stage");

  // a non-final vertex is always followed by more of the same expansion
  a_no_early_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("gap inside an expansion");

endmodule
